// File: rtl/core/lob_pkg.sv
// Package for the limit order book matcher.
// Holds payload structs, book entry type, cell opcodes and report codes.
// No dependencies.
package lob_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int MAX_REPORTS = 64;
  localparam int NREP_W = $clog2(MAX_REPORTS + 1);
  localparam logic [NREP_W-1:0] NREP_MAX = NREP_W'(MAX_REPORTS);
  localparam logic [NREP_W-1:0] NREP_LAST = NREP_W'(MAX_REPORTS - 1);

  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_FILL   = 2'd1;
  localparam logic [1:0] ST_PFILL  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef struct packed {
    logic [15:0] order_ref;
    logic        side;
    logic [19:0] limit_price;
    logic [15:0] order_qty;
  } in_t;

  typedef struct packed {
    logic [15:0] rep_ref;
    logic        rep_side;
    logic [1:0]  exec_status;
    logic [15:0] exec_qty;
    logic [19:0] exec_price;
    logic        last_report;
  } out_t;

  typedef struct packed {
    logic [15:0] ref_id;
    logic [19:0] price;
    logic [15:0] qty;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_POP    = 2'd1,
    OP_REDUCE = 2'd2,
    OP_INSERT = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        is_bid;
    entry_t      new_ent;
    logic [15:0] dec_qty;
  } book_cmd_t;

  typedef struct packed {
    logic   head_valid;
    entry_t head;
    logic   sec_valid;
    entry_t sec;
    logic   full;
  } book_stat_t;

endpackage

// File: rtl/core/limit_order_book_matcher.sv
// Limit order book matcher, price-time priority, two chains of book cells.
// Sequence: for each fill the match step registers the aggressor's report and the pass
// step the resting order's report; when nothing more crosses, a final step rests the
// remainder, with a new-order report if nothing filled, or rejects it if its side is full.
// Output stalls hold these steps; in_stall is high outside idle, so one order at a time.
// Reset: rst_n synchronous active low empties both book sides and the output.
module limit_order_book_matcher
  import lob_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_PASS  = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  in_t               ord_r, ord_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [NREP_W-1:0] n_r, n_nxt;
  out_t              pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  book_cmd_t  bid_cmd, ask_cmd;
  book_stat_t bid_stat, ask_stat;
  book_stat_t opp, own;
  book_cmd_t  opp_cmd, own_cmd;

  logic        can_out, n_full, slot, emit_we;
  out_t        rep;
  logic        cross0, cross1;
  logic [15:0] mq;

  lob_chain u_bid (.clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .stat(bid_stat));
  lob_chain u_ask (.clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .stat(ask_stat));

  always_comb begin
    opp = ord_r.side ? bid_stat : ask_stat;
    own = ord_r.side ? ask_stat : bid_stat;
    cross0 = ord_r.side ? (ord_r.limit_price <= opp.head.price)
                        : (ord_r.limit_price >= opp.head.price);
    cross1 = ord_r.side ? (ord_r.limit_price <= opp.sec.price)
                        : (ord_r.limit_price >= opp.sec.price);
    mq = (rem_r < opp.head.qty) ? rem_r : opp.head.qty;
    can_out = !out_valid_r || !out_stall;
    n_full  = (n_r == NREP_MAX);
    slot    = n_full || can_out;

    state_nxt = state_r;
    ord_nxt   = ord_r;
    rem_nxt   = rem_r;
    pass_nxt  = pass_r;
    emit_we   = 1'b0;
    rep       = '0;

    opp_cmd         = '0;
    opp_cmd.op      = OP_HOLD;
    opp_cmd.is_bid  = ord_r.side;
    opp_cmd.dec_qty = rem_r;
    own_cmd         = '0;
    own_cmd.op      = OP_HOLD;
    own_cmd.is_bid  = !ord_r.side;
    own_cmd.new_ent = '{ref_id: ord_r.order_ref, price: ord_r.limit_price, qty: rem_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ord_nxt   = in_data;
          rem_nxt   = in_data.order_qty;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (rem_r != 16'd0 && opp.head_valid && cross0) begin
          if (slot) begin
            emit_we = 1'b1;
            rep = '{rep_ref: ord_r.order_ref, rep_side: ord_r.side,
                    exec_status: (rem_r <= opp.head.qty) ? ST_FILL : ST_PFILL,
                    exec_qty: mq, exec_price: opp.head.price, last_report: 1'b0};
            pass_nxt = '{rep_ref: opp.head.ref_id, rep_side: !ord_r.side,
                         exec_status: (rem_r >= opp.head.qty) ? ST_FILL : ST_PFILL,
                         exec_qty: mq, exec_price: opp.head.price,
                         last_report: 1'b1};
            if (rem_r > opp.head.qty && opp.sec_valid && cross1) begin
              pass_nxt.last_report = 1'b0;
            end else if (rem_r > opp.head.qty && own.full) begin
              pass_nxt.last_report = 1'b0;
            end
            opp_cmd.op = (rem_r >= opp.head.qty) ? OP_POP : OP_REDUCE;
            rem_nxt    = rem_r - mq;
            state_nxt  = S_PASS;
          end
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_PASS: begin
        if (slot) begin
          emit_we   = 1'b1;
          rep       = pass_r;
          state_nxt = S_MATCH;
        end
      end
      S_FINAL: begin
        if (rem_r != 16'd0 && own.full) begin
          if (slot) begin
            emit_we = 1'b1;
            rep = '{rep_ref: ord_r.order_ref, rep_side: ord_r.side,
                    exec_status: ST_REJECT, exec_qty: rem_r,
                    exec_price: ord_r.limit_price, last_report: 1'b1};
            state_nxt = S_IDLE;
          end
        end else if (n_r != '0) begin
          if (rem_r != 16'd0) begin
            own_cmd.op = OP_INSERT;
          end
          state_nxt = S_IDLE;
        end else if (can_out) begin
          emit_we = 1'b1;
          rep = '{rep_ref: ord_r.order_ref, rep_side: ord_r.side,
                  exec_status: ST_NEW, exec_qty: ord_r.order_qty,
                  exec_price: ord_r.limit_price, last_report: 1'b1};
          if (rem_r != 16'd0) begin
            own_cmd.op = OP_INSERT;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (n_r == NREP_LAST) begin
      rep.last_report = 1'b1;
    end
    if (n_full) begin
      emit_we = 1'b0;
    end

    n_nxt = n_r;
    if (state_r == S_IDLE) begin
      n_nxt = '0;
    end else if (emit_we) begin
      n_nxt = n_r + NREP_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_we) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rep;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    bid_cmd = ord_r.side ? opp_cmd : own_cmd;
    ask_cmd = ord_r.side ? own_cmd : opp_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ord_r      <= ord_nxt;
    rem_r      <= rem_nxt;
    pass_r     <= pass_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_we && out_valid_r |-> !out_stall)
    else $error("report written over a stalled transaction");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NREP_MAX)
    else $error("report count beyond limit");

  a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINAL && state_nxt != S_FINAL |=> state_r == S_IDLE)
    else $error("sequencer left final step to a busy state");
`endif

endmodule

// File: rtl/core/lob_cell.sv
// One book cell: holds a single resting order and trades it with its neighbors.
// Depends on lob_pkg.
module lob_cell
  import lob_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  book_cmd_t  cmd,
  input  logic       left_valid,
  input  entry_t     left_ent,
  input  logic       left_keep,
  input  logic       right_valid,
  input  entry_t     right_ent,
  output logic       valid,
  output entry_t     ent,
  output logic       keep
);

  logic   valid_r, valid_nxt;
  entry_t ent_r, ent_nxt;

  always_comb begin
    keep = valid_r && (cmd.is_bid ? !(ent_r.price < cmd.new_ent.price)
                                  : !(ent_r.price > cmd.new_ent.price));
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    case (cmd.op)
      OP_POP: begin
        valid_nxt = right_valid;
        ent_nxt   = right_ent;
      end
      OP_REDUCE: begin
        ent_nxt.qty = ent_r.qty - cmd.dec_qty;
      end
      OP_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            valid_nxt = 1'b1;
            ent_nxt   = cmd.new_ent;
          end else begin
            valid_nxt = left_valid;
            ent_nxt   = left_ent;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign valid = valid_r;
  assign ent   = ent_r;

endmodule

// File: rtl/core/lob_chain.sv
// One side of the book as a row of lob_cell, best price at cell 0.
// Depends on lob_pkg and lob_cell.
module lob_chain
  import lob_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  book_cmd_t  cmd,
  output book_stat_t stat
);

  logic   cv [0:BOOK_DEPTH];
  entry_t ce [0:BOOK_DEPTH];
  logic   kl [0:BOOK_DEPTH];

  assign cv[BOOK_DEPTH] = 1'b0;
  assign ce[BOOK_DEPTH] = '0;
  assign kl[0] = 1'b1;

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    book_cmd_t ccmd;
    logic      lv;
    entry_t    le;
    always_comb begin
      ccmd = cmd;
      if (cmd.op == OP_REDUCE && i != 0) begin
        ccmd.op = OP_HOLD;
      end
    end
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign le = '0;
    end else begin : g_body
      assign lv = cv[i-1];
      assign le = ce[i-1];
    end
    lob_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (ccmd),
      .left_valid  (lv),
      .left_ent    (le),
      .left_keep   (kl[i]),
      .right_valid (cv[i+1]),
      .right_ent   (ce[i+1]),
      .valid       (cv[i]),
      .ent         (ce[i]),
      .keep        (kl[i+1])
    );
  end

  assign stat.head_valid = cv[0];
  assign stat.head       = ce[0];
  assign stat.sec_valid  = cv[1];
  assign stat.sec        = ce[1];
  assign stat.full       = cv[BOOK_DEPTH-1];

endmodule
